>>> design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helpers of the Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // Fixed-point format of every plane coordinate.
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int SAT_IN_W  = 48;

  // Image size bound and field widths.
  localparam int          DIM_W   = 13;
  localparam int          PIX_W   = 12;
  localparam int          STEP_W  = 31;
  localparam int          COUNT_W = 16;
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // Escape threshold: |z|^2 > 4 with 2*FRAC_BITS fraction bits.
  localparam int          THR_BITS = 2 * FRAC_BITS + 2;
  localparam logic [63:0] ESC_THR  = (THR_BITS <= 63) ? (64'd1 << THR_BITS) : {64{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_CENTER_RE       = 3'd2,
    REG_CENTER_IM       = 3'd3,
    REG_PIXEL_STEP      = 3'd4,
    REG_ITERATION_LIMIT = 3'd5
  } cfg_idx_e;

  // One complex point c as handed from the front end to the iteration engine.
  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } point_t;

  // View settings used by the pixel mapper.
  typedef struct packed {
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic signed [COORD_W-1:0] center_re;
    logic signed [COORD_W-1:0] center_im;
    logic [STEP_W-1:0]         step;
  } map_cfg_t;

  // Clamp a wide signed value to the 32-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_IN_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v[SAT_IN_W-1:COORD_W-1] == {(SAT_IN_W-COORD_W+1){v[SAT_IN_W-1]}}) begin
      res = signed'(v[COORD_W-1:0]);
    end else if (v[SAT_IN_W-1]) begin
      res = signed'({1'b1, {(COORD_W-1){1'b0}}});
    end else begin
      res = signed'({1'b0, {(COORD_W-1){1'b1}}});
    end
    return res;
  endfunction

  // Image size above the bound is taken as the bound.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

>>> design/mbe_fifo.sv
// ----------------------------------------------------------------------------
// mbe_fifo
// Small queue of mapped points between the pixel mapper and the engine.
// ----------------------------------------------------------------------------
module mbe_fifo
  import mbe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  point_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output point_t data_o,
  output logic   valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  point_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Pixel mapper: accepts pixel transactions and turns each into a point c.
// ----------------------------------------------------------------------------
module mbe_front
  import mbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_cfg_t         cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] pixel_col_i,
  input  logic [PIX_W-1:0] pixel_row_i,
  output logic             push_o,
  output point_t           point_o,
  input  logic             full_i
);

  localparam int OFS_W  = PIX_W + 3;
  localparam int PROD_W = OFS_W + COORD_W;

  logic [DIM_W-1:0]         width_eff, height_eff;
  logic signed [OFS_W-1:0]  dx, dy;
  logic signed [COORD_W-1:0] step_s;
  logic signed [PROD_W-1:0] prod_re_q, prod_re_d;
  logic signed [PROD_W-1:0] prod_im_q, prod_im_d;
  logic                     s1_valid_q, s1_valid_d;
  logic                     in_fire;
  logic signed [PROD_W-1:0] half_re, half_im;
  logic signed [PROD_W-1:0] ctr_re_ext, ctr_im_ext;
  logic signed [PROD_W-1:0] sum_re, sum_im;
  logic signed [SAT_IN_W-1:0] sum_re_w, sum_im_w;

  // Hold the pixel while the mapped point cannot enter the queue.
  assign in_stall_o = s1_valid_q && full_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q;

  // Pixel offset from the image center in half pixels, times the step.
  assign width_eff  = clamp_dim(cfg_i.width);
  assign height_eff = clamp_dim(cfg_i.height);
  assign dx     = signed'({2'b00, pixel_col_i, 1'b0}) - signed'({2'b00, width_eff});
  assign dy     = signed'({2'b00, height_eff}) - signed'({2'b00, pixel_row_i, 1'b0});
  assign step_s = signed'({1'b0, cfg_i.step});
  assign prod_re_d = dx * step_s;
  assign prod_im_d = dy * step_s;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_valid_q && !full_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
    end
  end

  // Halve with floor, add the view center and clamp to the coordinate range.
  assign half_re    = prod_re_q >>> 1;
  assign half_im    = prod_im_q >>> 1;
  assign ctr_re_ext = signed'({{(PROD_W-COORD_W){cfg_i.center_re[COORD_W-1]}},
                               cfg_i.center_re});
  assign ctr_im_ext = signed'({{(PROD_W-COORD_W){cfg_i.center_im[COORD_W-1]}},
                               cfg_i.center_im});
  assign sum_re     = half_re + ctr_re_ext;
  assign sum_im     = half_im + ctr_im_ext;
  assign sum_re_w   = signed'({{(SAT_IN_W-PROD_W){sum_re[PROD_W-1]}}, sum_re});
  assign sum_im_w   = signed'({{(SAT_IN_W-PROD_W){sum_im[PROD_W-1]}}, sum_im});
  assign point_o.re = sat_coord(sum_re_w);
  assign point_o.im = sat_coord(sum_im_w);

endmodule

>>> design/mbe_back.sv
// ----------------------------------------------------------------------------
// mbe_back
// Iteration engine: runs z = z^2 + c for one point and delivers its count.
// ----------------------------------------------------------------------------
module mbe_back
  import mbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COUNT_W-1:0] limit_i,
  input  logic               q_valid_i,
  input  point_t             q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] escape_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic                      out_valid_q;
  logic [COUNT_W-1:0]        escape_count_q;
  logic signed [COORD_W-1:0] x_q, y_q, cx_q, cy_q;
  logic signed [63:0]        xy_q, xx_q, yy_q;
  logic [COUNT_W-1:0]        cnt_q, res_q;
  logic signed [63:0]        xy_sh, diff, diff_sh, cx_ext, cy_ext, re_sum, im_sum;
  logic signed [COORD_W-1:0] x_new, y_new;
  logic [63:0]               r2;
  logic [COUNT_W:0]          cnt_next;
  logic                      escaped, last_count, out_load;

  assign pop_o          = (state_q == ST_IDLE) && q_valid_i;
  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;
  assign out_load       = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next z from the registered products, floored and clamped.
  assign xy_sh   = xy_q >>> (FRAC_BITS - 1);
  assign diff    = xx_q - yy_q;
  assign diff_sh = diff >>> FRAC_BITS;
  assign cx_ext  = signed'({{(64-COORD_W){cx_q[COORD_W-1]}}, cx_q});
  assign cy_ext  = signed'({{(64-COORD_W){cy_q[COORD_W-1]}}, cy_q});
  assign re_sum  = diff_sh + cx_ext;
  assign im_sum  = xy_sh + cy_ext;
  assign x_new   = sat_coord(re_sum[SAT_IN_W-1:0]);
  assign y_new   = sat_coord(im_sum[SAT_IN_W-1:0]);

  // Escape test on the current z and end of the count range.
  assign r2         = xx_q + yy_q;
  assign escaped    = (cnt_q != '0) && (r2 > ESC_THR);
  assign cnt_next   = {1'b0, cnt_q} + 1'b1;
  assign last_count = cnt_next >= {1'b0, limit_i};

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      escape_count_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q    <= 1'b1;
        escape_count_q <= res_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (escaped || last_count) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          x_q   <= q_data_i.re;
          y_q   <= q_data_i.im;
          cx_q  <= q_data_i.re;
          cy_q  <= q_data_i.im;
          cnt_q <= '0;
        end
      end
      ST_MUL: begin
        xy_q <= x_q * y_q;
        xx_q <= x_q * x_q;
        yy_q <= y_q * y_q;
      end
      ST_UPD: begin
        if (escaped) begin
          res_q <= cnt_q;
        end else if (last_count) begin
          res_q <= '0;
        end else begin
          x_q   <= x_new;
          y_q   <= y_new;
          cnt_q <= cnt_next[COUNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Mandelbrot escape-time unit: pixel in, first escaping iteration count out.
// ----------------------------------------------------------------------------
// Each pixel transaction is mapped to a point c by the front end, which
// registers the offset products, and queued; each iteration of the engine
// then passes through ST_MUL, which forms the three 32x32 products, and
// ST_UPD, which updates z and does the escape test.
// The engine works on one point at a time; the queue lets new pixels be
// accepted and a finished count wait in the output register meanwhile.
// Configuration may only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_col_i,
  input  logic [PIX_W-1:0]      pixel_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COUNT_W-1:0]    escape_count_o
);

  map_cfg_t           map_cfg_q;
  logic [COUNT_W-1:0] limit_q;
  logic               push, full, pop, q_valid;
  point_t             push_data, pop_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cfg_q.width     <= 13'd800;
      map_cfg_q.height    <= 13'd600;
      map_cfg_q.center_re <= 32'shF800_0000;
      map_cfg_q.center_im <= '0;
      map_cfg_q.step      <= 31'd1087334;
      limit_q             <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH:     map_cfg_q.width     <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    map_cfg_q.height    <= cfg_wdata_i[DIM_W-1:0];
        REG_CENTER_RE:       map_cfg_q.center_re <= signed'(cfg_wdata_i);
        REG_CENTER_IM:       map_cfg_q.center_im <= signed'(cfg_wdata_i);
        REG_PIXEL_STEP:      map_cfg_q.step      <= cfg_wdata_i[STEP_W-1:0];
        REG_ITERATION_LIMIT: limit_q             <= cfg_wdata_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pixel mapper.
  mbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (map_cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .push_o      (push),
    .point_o     (push_data),
    .full_i      (full)
  );

  // Queue of mapped points.
  mbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .valid_o (q_valid)
  );

  // Iteration engine.
  mbe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_i        (limit_q),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o)
  );

endmodule

>>> tb/mandelbrot_escape_time_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Self-checking testbench for the Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
// Pixel transactions are driven through the valid/stall input channel while
// the view registers are changed between bursts. Every accepted pixel is
// mapped and iterated by a behavioral predictor that mirrors the fixed-point
// datapath. Each returned escape count is compared in order against the
// predicted count. Directed tests cover reset defaults, tiny and huge
// iteration limits, image size clamping, a zero pixel step, coordinate
// saturation and writes to unused register indexes. These are followed by
// random views under several sender and receiver throttling patterns.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  // Unused register indexes; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 1530;

  // Fixed-point constants with 28 fraction bits.
  localparam logic [31:0] FX_TWO       = 32'h2000_0000;
  localparam logic [31:0] FX_MINUS_TWO = 32'hE000_0000;
  localparam logic [31:0] FX_HALF      = 32'h0800_0000;
  localparam logic [31:0] FX_M_HALF    = 32'hF800_0000;
  localparam logic [31:0] FX_ZERO      = 32'h0000_0000;
  localparam logic [31:0] FX_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN       = 32'h8000_0000;
  localparam logic [31:0] STEP_DEFAULT = 32'd1087334;

  typedef struct {
    logic [PIX_W-1:0]   col;
    logic [PIX_W-1:0]   row;
    logic [COUNT_W-1:0] count;
  } pixel_expect_t;

  // DUT connections. Every input starts at a known value.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_col_i = '0;
  logic [PIX_W-1:0]      pixel_row_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COUNT_W-1:0]    escape_count_o;

  // Shadow copy of the view registers, starting at their reset values.
  logic [DIM_W-1:0]          view_width     = 13'd800;
  logic [DIM_W-1:0]          view_height    = 13'd600;
  logic signed [COORD_W-1:0] view_center_re = FX_M_HALF;
  logic signed [COORD_W-1:0] view_center_im = FX_ZERO;
  logic [STEP_W-1:0]         view_step      = STEP_DEFAULT[STEP_W-1:0];
  logic [COUNT_W-1:0]        iter_limit     = 16'd200;

  // Predicted counts of accepted pixels, oldest first.
  pixel_expect_t pending_counts[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int fail_count      = 0;
  int pixels_sent     = 0;
  int results_seen    = 0;
  int escaped_seen    = 0;
  int views_applied   = 0;
  int max_count_seen  = 0;

  mandelbrot_escape_time uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .escape_count_o (escape_count_o)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp a wide value to the signed 32-bit coordinate range.
  function automatic longint clamp_coord(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Map a pixel to its plane point and iterate until escape or the limit.
  function automatic logic [COUNT_W-1:0] escape_time_of(input logic [PIX_W-1:0] col,
                                                        input logic [PIX_W-1:0] row);
    longint w, h, cx, cy, x, y, x2, y2, nx, ny;
    longint unsigned mag2;
    logic [COUNT_W-1:0] count;
    w = (view_width > MAX_DIM) ? longint'(MAX_DIM) : longint'(view_width);
    h = (view_height > MAX_DIM) ? longint'(MAX_DIM) : longint'(view_height);
    cx = clamp_coord(longint'(view_center_re)
                     + (((2 * longint'(col) - w) * longint'(view_step)) >>> 1));
    cy = clamp_coord(longint'(view_center_im)
                     + (((h - 2 * longint'(row)) * longint'(view_step)) >>> 1));
    count = '0;
    x = cx;
    y = cy;
    x2 = x * x;
    y2 = y * y;
    for (int n = 1; n < iter_limit; n++) begin
      ny = clamp_coord(((x * y) >>> (FRAC_BITS - 1)) + cy);
      nx = clamp_coord(((x2 - y2) >>> FRAC_BITS) + cx);
      x = nx;
      y = ny;
      x2 = x * x;
      y2 = y * y;
      mag2 = longint'(x2) + longint'(y2);
      if (mag2 > ESC_THR) begin
        count = n[COUNT_W-1:0];
        break;
      end
    end
    return count;
  endfunction

  // Write one register and mirror the write in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_IMAGE_WIDTH:     view_width     = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT:    view_height    = data[DIM_W-1:0];
      REG_CENTER_RE:       view_center_re = signed'(data);
      REG_CENTER_IM:       view_center_im = signed'(data);
      REG_PIXEL_STEP:      view_step      = data[STEP_W-1:0];
      REG_ITERATION_LIMIT: iter_limit     = data[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Program a complete view; every register is written.
  task automatic set_view(input logic [31:0] w, input logic [31:0] h,
                          input logic [31:0] cre, input logic [31:0] cim,
                          input logic [31:0] step, input logic [31:0] lim);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CENTER_RE, cre);
    write_reg(REG_CENTER_IM, cim);
    write_reg(REG_PIXEL_STEP, step);
    write_reg(REG_ITERATION_LIMIT, lim);
    views_applied++;
  endtask

  // Offer one pixel transaction, with optional idle cycles before it, and
  // record its predicted count once it is accepted.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    pixel_expect_t item;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (in_stall_o);
    item.col   = col;
    item.row   = row;
    item.count = escape_time_of(col, row);
    pending_counts.insert(pending_counts.size(), item);
    pixels_sent++;
  endtask

  // Stop offering pixels and wait until every outstanding count is back.
  task automatic wait_all_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk_i);
  endtask

  // Receiver throttling, redrawn every cycle.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_expect_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (escape_count_o != '0) escaped_seen++;
      if (int'(escape_count_o) > max_count_seen) max_count_seen = int'(escape_count_o);
      if (pending_counts.size() == 0) begin
        $error("escape_count: unexpected result %0d with no pixel outstanding",
               escape_count_o);
        fail_count++;
      end else begin
        head = pending_counts.pop_front();
        if (escape_count_o !== head.count) begin
          $error("escape_count mismatch for pixel (%0d,%0d): expected %0d, actual %0d",
                 head.col, head.row, head.count, escape_count_o);
          fail_count++;
        end
      end
    end
  end

  // The view right after reset, including a pixel outside the image.
  task automatic test_reset_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'd799, 12'd599);
    send_pixel(12'hFFF, 12'hFFF);
    wait_all_done();
  endtask

  // Limits of zero and one try no count; a limit of two tries exactly one.
  task automatic test_small_limit();
    set_view(32'd800, 32'd600, FX_M_HALF, FX_ZERO, STEP_DEFAULT, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd400, 12'd300);
    wait_all_done();
    write_reg(REG_ITERATION_LIMIT, 32'd1);
    send_pixel(12'd0, 12'd300);
    wait_all_done();
    write_reg(REG_ITERATION_LIMIT, 32'd2);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd400, 12'd300);
    wait_all_done();
  endtask

  // Sizes above the bound are clamped; a zero size is used as it is.
  task automatic test_image_size_clamp();
    set_view(32'd8191, 32'd0, FX_ZERO, FX_ZERO, 32'h0004_0000, 32'd16);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    wait_all_done();
    set_view(32'd4097, 32'd8191, FX_M_HALF, FX_ZERO, 32'h0004_0000, 32'd16);
    send_pixel(12'd2048, 12'd0);
    wait_all_done();
  endtask

  // A zero step puts every pixel on the view center.
  task automatic test_zero_step();
    set_view(32'd800, 32'd600, FX_MINUS_TWO, FX_ZERO, 32'd0, 32'd40);
    send_pixel(12'd123, 12'd456);
    wait_all_done();
    set_view(32'd800, 32'd600, FX_HALF, FX_HALF, 32'd0, 32'd40);
    send_pixel(12'hFFF, 12'd0);
    wait_all_done();
  endtask

  // Huge step and extreme centers drive c and z into saturation.
  task automatic test_coordinate_overflow();
    set_view(32'd800, 32'd600, FX_MAX, FX_MAX, 32'h7FFF_FFFF, 32'd8);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd400, 12'd300);
    wait_all_done();
    set_view(32'd800, 32'd600, FX_MIN, FX_MIN, 32'h7FFF_FFFF, 32'd8);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd400, 12'd300);
    wait_all_done();
  endtask

  // The largest limit: one bounded point runs the full span, one escapes.
  task automatic test_long_limit();
    set_view(32'd1, 32'd1, FX_ZERO, FX_ZERO, 32'd0, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    wait_all_done();
    write_reg(REG_CENTER_RE, FX_TWO);
    send_pixel(12'd0, 12'd0);
    wait_all_done();
  endtask

  // Writes to unused indexes leave the view untouched.
  task automatic test_spare_index();
    set_view(32'd800, 32'd600, FX_M_HALF, FX_ZERO, STEP_DEFAULT, 32'd64);
    write_reg(IDX_SPARE_A, $urandom);
    write_reg(IDX_SPARE_B, $urandom);
    send_pixel(12'd150, 12'd250);
    send_pixel(12'd600, 12'd100);
    wait_all_done();
  endtask

  // Random views in bursts, rotating through the throttling patterns.
  task automatic test_random_views();
    int sent, phase, burst, wc, hc, eff_w, eff_h, col_max, row_max, pick;
    logic [31:0] cre, cim, step, lim, garbage;
    logic [PIX_W-1:0] col, row;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase

      // Image size, mostly in range, sometimes above the bound or zero.
      wc = ($urandom_range(99) < 90) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
      hc = ($urandom_range(99) < 90) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
      eff_w = (wc > 4096) ? 4096 : wc;
      eff_h = (hc > 4096) ? 4096 : hc;

      // Centers mostly within two units of the origin.
      if ($urandom_range(99) < 85) begin
        cre = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        cim = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      end else begin
        cre = $urandom;
        cim = $urandom;
      end

      // Step mostly spans about four units across the image, zoomed in.
      pick = $urandom_range(99);
      if (pick < 80) step = (32'h4000_0000 / ((eff_w == 0) ? 1 : eff_w)) >> $urandom_range(0, 8);
      else if (pick < 90) step = $urandom;
      else if (pick < 95) step = 32'd0;
      else step = $urandom_range(1, 16);

      // Limits stay small most of the time to keep the run short.
      pick = $urandom_range(99);
      if (pick < 5) lim = $urandom_range(0, 1);
      else if (pick < 15) lim = $urandom_range(100, 200);
      else lim = $urandom_range(2, 64);

      // Unused upper data bits carry random junk.
      garbage = $urandom;
      set_view({garbage[31:13], wc[12:0]}, {garbage[31:13], hc[12:0]}, cre, cim,
               {garbage[31], step[30:0]}, {garbage[31:16], lim[15:0]});

      col_max = (eff_w == 0) ? 4095 : eff_w - 1;
      row_max = (eff_h == 0) ? 4095 : eff_h - 1;
      burst = $urandom_range(30, 80);
      repeat (burst) begin
        if ($urandom_range(99) < 85) begin
          col = PIX_W'($urandom_range(0, col_max));
          row = PIX_W'($urandom_range(0, row_max));
        end else begin
          col = PIX_W'($urandom_range(0, 4095));
          row = PIX_W'($urandom_range(0, 4095));
        end
        // Now and then let the pipeline run completely dry.
        if ($urandom_range(99) == 0) wait_all_done();
        send_pixel(col, row);
        sent++;
      end
      wait_all_done();
      phase++;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_view();
    test_small_limit();
    test_image_size_clamp();
    test_zero_step();
    test_coordinate_overflow();
    test_long_limit();
    test_spare_index();
    test_random_views();

    wait_all_done();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d pixel transactions, checked %0d results across %0d view settings.",
             pixels_sent, results_seen, views_applied);
    $display("%0d pixels escaped, %0d stayed bounded; largest count %0d.",
             escaped_seen, results_seen - escaped_seen, max_count_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #16_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
